>>> design/amr_pkg.sv
// Shared types and constants for the adjacency matrix reachability block.
`default_nettype none
package amr_pkg;

  localparam int VW     = 4;   // vertex field width
  localparam int VMAX   = 16;  // vertices that a 4-bit field can name
  localparam int CNT_W  = 5;   // vertex_count register width
  localparam int ADDR_W = 3;   // APB address width
  localparam int DATA_W = 32;  // APB data width

  // longest run of non-final path words before the source is forced out
  localparam logic [VW-1:0] PATH_MAX = 4'd15;

  // register index, taken from paddr[2]
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_REACH  = 2'd2,
    OP_PATH   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WALK,
    ST_RESULT
  } state_t;

  typedef struct packed {
    op_t           operation;
    logic [VW-1:0] vertex_a;
    logic [VW-1:0] vertex_b;
  } cmd_word_t;

  typedef struct packed {
    logic          ok;
    logic [VW-1:0] path_vertex;
    logic          last;
  } res_word_t;

  // neighbor pick: any candidate left, and the lowest one
  typedef struct packed {
    logic          any;
    logic [VW-1:0] index;
  } pick_t;

endpackage
`default_nettype wire

>>> design/amr_pick.sv
// Candidate mask and lowest-neighbor pick for one search step.
`default_nettype none
module amr_pick #(
  parameter int NS = 16
) (
  input  logic [NS-1:0] row,
  input  logic [NS-1:0] live,
  input  logic [NS-1:0] visited,
  output amr_pkg::pick_t pick
);
  import amr_pkg::*;

  logic [NS-1:0] cand;

  always_comb begin
    cand       = row & live & ~visited;
    pick.any   = |cand;
    pick.index = '0;
    // scan high to low so the lowest set bit wins
    for (int i = NS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick.index = VW'(i);
      end
    end
  end

endmodule
`default_nettype wire

>>> design/adjacency_matrix_reachability.sv
// Top level: undirected graph store with depth-first reach and path queries.
`default_nettype none
// Keeps an undirected graph of up to min(MAX_VERTICES, 16) vertices as a
// symmetric bit matrix in flops, cleared by rst. Each cmd word is an insert,
// remove, reach query or path query on vertices vertex_a and vertex_b; a
// vertex at or above the count in effect (vertex_count, capped by the
// storage size) makes the word a no-op with ok=0. Queries run a depth-first
// search with an explicit stack, lowest-numbered neighbor first. One item
// is in flight at a time and cmd_ready is high only while idle. An update or
// rejected query goes from ST_IDLE to ST_RESULT, which emits its res word. A
// search takes one stack step at a time through the shared neighbor-pick unit,
// each vertex pushed and popped at most once. A path query then streams one
// res word per cycle while res is not stalled, from the destination back to
// the source (last=1 on the source), following parent links written by that
// search. Stalls on res hold the pending word and the walk.
// vertex_count lives at APB byte address 0; writes belong in idle periods.
module adjacency_matrix_reachability #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // command channel
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  amr_pkg::cmd_word_t             cmd,
  // result channel
  output logic                           res_valid,
  input  logic                           res_ready,
  output amr_pkg::res_word_t             res,
  // APB config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [amr_pkg::ADDR_W-1:0]     paddr,
  input  logic [amr_pkg::DATA_W-1:0]     pwdata,
  output logic [amr_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  import amr_pkg::*;

  // vertices actually stored, index and stack-depth widths
  localparam int NS = (MAX_VERTICES < VMAX) ? MAX_VERTICES : VMAX;
  localparam int IW = $clog2(NS);
  localparam int DW = $clog2(NS + 1);

  // ---------------- config register ----------------
  logic [CNT_W-1:0] vertex_count;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_VERTEX_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CNT_W'(VMAX);
    end else if (cfg_wr) begin
      vertex_count <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? DATA_W'(vertex_count) : '0;

  // ---------------- state ----------------
  state_t          state, state_next;
  logic [NS-1:0]   rows    [NS];   // adjacency matrix
  logic [IW-1:0]   parent  [NS];   // search tree links
  logic [IW-1:0]   stack   [NS];   // DFS stack
  logic [DW-1:0]   depth;
  logic [NS-1:0]   visited;
  op_t             op_q;
  logic [IW-1:0]   a_q, b_q;       // source, destination
  logic            ok_q;           // pending single-word result
  logic [IW-1:0]   v_q;            // path walk cursor
  logic [VW-1:0]   k_q;            // path words sent

  // ---------------- combinational control ----------------
  logic [DW-1:0]   nv;             // count in effect
  logic [NS-1:0]   live;
  logic            pair_ok, accept, slot_free;
  logic [DW-1:0]   depth_m1;
  logic [IW-1:0]   top;
  pick_t           pick;
  logic [IW-1:0]   nxt;
  logic            hit, full, walk_end;
  logic            emit;
  res_word_t       emit_word;

  always_comb begin
    if (vertex_count > CNT_W'(NS)) begin
      nv = DW'(NS);
    end else begin
      nv = vertex_count[DW-1:0];
    end
    for (int i = 0; i < NS; i++) begin
      live[i] = (DW'(i) < nv);
    end
  end

  assign pair_ok   = ({1'b0, cmd.vertex_a} < CNT_W'(nv)) &&
                     ({1'b0, cmd.vertex_b} < CNT_W'(nv));
  assign cmd_ready = (state == ST_IDLE);
  assign accept    = cmd_valid & cmd_ready;
  assign slot_free = !res_valid || res_ready;

  assign depth_m1 = depth - DW'(1);
  assign top      = stack[depth_m1[IW-1:0]];

  amr_pick #(.NS(NS)) u_pick (
    .row     (rows[top]),
    .live    (live),
    .visited (visited),
    .pick    (pick)
  );

  assign nxt      = pick.index[IW-1:0];
  assign hit      = pick.any && (nxt == b_q);
  assign full     = (depth >= nv);
  assign walk_end = (v_q == a_q) || (k_q == PATH_MAX);

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_word  = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd.operation == OP_INSERT || cmd.operation == OP_REMOVE || !pair_ok) begin
            state_next = ST_RESULT;
          end else if (cmd.vertex_a == cmd.vertex_b) begin
            state_next = (cmd.operation == OP_REACH) ? ST_RESULT : ST_WALK;
          end else begin
            state_next = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        priority if (depth == '0) begin
          state_next = ST_RESULT;
        end else if (!pick.any) begin
          state_next = ST_SEARCH;
        end else if (hit) begin
          state_next = (op_q == OP_REACH) ? ST_RESULT : ST_WALK;
        end else if (full) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_SEARCH;
        end
      end
      ST_WALK: begin
        if (slot_free) begin
          emit                  = 1'b1;
          emit_word.ok          = 1'b1;
          emit_word.path_vertex = VW'(walk_end ? a_q : v_q);
          emit_word.last        = walk_end;
          if (walk_end) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_RESULT: begin
        if (slot_free) begin
          emit           = 1'b1;
          emit_word.ok   = ok_q;
          emit_word.last = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // adjacency matrix: both symmetric bits in the same cycle, one bit for a self loop
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        rows[i] <= '0;
      end
    end else if (accept && pair_ok &&
                 (cmd.operation == OP_INSERT || cmd.operation == OP_REMOVE)) begin
      rows[cmd.vertex_a[IW-1:0]][cmd.vertex_b[IW-1:0]] <= (cmd.operation == OP_INSERT);
      if (cmd.vertex_a != cmd.vertex_b) begin
        rows[cmd.vertex_b[IW-1:0]][cmd.vertex_a[IW-1:0]] <= (cmd.operation == OP_INSERT);
      end
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      depth   <= '0;
      visited <= '0;
    end else if (accept) begin
      op_q  <= cmd.operation;
      a_q   <= cmd.vertex_a[IW-1:0];
      b_q   <= cmd.vertex_b[IW-1:0];
      ok_q  <= pair_ok;
      v_q   <= cmd.vertex_b[IW-1:0];
      k_q   <= '0;
      if (pair_ok && (cmd.operation == OP_REACH || cmd.operation == OP_PATH)) begin
        visited                       <= NS'(1) << cmd.vertex_a[IW-1:0];
        parent[cmd.vertex_a[IW-1:0]]  <= cmd.vertex_a[IW-1:0];
        stack[0]                      <= cmd.vertex_a[IW-1:0];
        depth                         <= DW'(1);
      end
    end else if (state == ST_SEARCH) begin
      if (depth == '0) begin
        ok_q <= 1'b0;
      end else if (!pick.any) begin
        depth <= depth_m1;                     // dead end: pop
      end else begin
        visited     <= visited | (NS'(1) << nxt);
        parent[nxt] <= top;
        if (hit) begin
          ok_q <= 1'b1;
        end else if (full) begin
          ok_q <= 1'b0;
        end else begin
          stack[depth[IW-1:0]] <= nxt;
          depth                <= depth + DW'(1);
        end
      end
    end else if (state == ST_WALK && slot_free && !walk_end) begin
      v_q <= parent[v_q];
      k_q <= k_q + VW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= emit_word;
    end
  end

  // ---------------- assertions ----------------
  logic sym_ok;
  always_comb begin
    sym_ok = 1'b1;
    for (int i = 0; i < NS; i++) begin
      for (int j = 0; j < NS; j++) begin
        if (rows[i][j] != rows[j][i]) begin
          sym_ok = 1'b0;
        end
      end
    end
  end

  a_symmetric: assert property (@(posedge clk) disable iff (rst) sym_ok)
    else $error("adjacency matrix lost symmetry");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEARCH |-> depth <= nv)
    else $error("stack depth above vertex count");

  a_top_visited: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH && depth != '0) |-> visited[top])
    else $error("stack top not marked visited");

  a_walk_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && k_q == PATH_MAX && slot_free) |=> state == ST_IDLE)
    else $error("path walk ran past its limit");

endmodule
`default_nettype wire
